// File: rtl/core/urbuf_pkg.sv
// Shared types, sizes and pointer helpers for the serial buffer pair.
`default_nettype none

package urbuf_pkg;

  // Ring sizes. Each ring holds one byte fewer than its depth.
  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  // Depths at the width of a fill count.
  localparam logic [RX_PTR_W:0] RX_DEPTH_L = (RX_PTR_W + 1)'(RX_DEPTH);
  localparam logic [TX_PTR_W:0] TX_DEPTH_L = (TX_PTR_W + 1)'(TX_DEPTH);
  localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
  localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);

  // Field widths of the item and result beats.
  localparam int MODE_W = 3;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 6;

  // Input mode codes.
  localparam logic [MODE_W-1:0] MODE_RX_BYTE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TX_DONE = 3'd4;

  // Operation classes handed from the front to the back.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_RX_PUT  = 3'd1,
    OP_PEEK    = 3'd2,
    OP_READ    = 3'd3,
    OP_TX_PUT  = 3'd4,
    OP_TX_DONE = 3'd5
  } op_t;

  // One queued command.
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              rx_dropped;
    logic              write_rejected;
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic [CNT_W-1:0]  rx_count;
    logic [CNT_W-1:0]  tx_count;
  } res_t;

  // Next slot of the receive ring, wrapping at the depth.
  function automatic logic [RX_PTR_W-1:0] rx_adv(input logic [RX_PTR_W-1:0] p);
    rx_adv = (p == RX_LAST) ? '0 : p + 1'b1;
  endfunction

  // Next slot of the transmit ring, wrapping at the depth.
  function automatic logic [TX_PTR_W-1:0] tx_adv(input logic [TX_PTR_W-1:0] p);
    tx_adv = (p == TX_LAST) ? '0 : p + 1'b1;
  endfunction

  // Bytes held in the receive ring.
  function automatic logic [RX_PTR_W:0] rx_fill(input logic [RX_PTR_W-1:0] h,
                                                input logic [RX_PTR_W-1:0] t);
    if (h >= t) begin
      rx_fill = {1'b0, h} - {1'b0, t};
    end else begin
      rx_fill = RX_DEPTH_L + {1'b0, h} - {1'b0, t};
    end
  endfunction

  // Bytes queued in the transmit ring.
  function automatic logic [TX_PTR_W:0] tx_fill(input logic [TX_PTR_W-1:0] h,
                                                input logic [TX_PTR_W-1:0] t);
    if (h >= t) begin
      tx_fill = {1'b0, h} - {1'b0, t};
    end else begin
      tx_fill = TX_DEPTH_L + {1'b0, h} - {1'b0, t};
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/urbuf_front.sv
// Front end: accepts item beats, classifies the mode and queues commands.
`default_nettype none

module urbuf_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [urbuf_pkg::MODE_W-1:0] in_mode,
  input  wire logic [urbuf_pkg::BYTE_W-1:0] in_byte_in,
  output logic                           cmd_valid,
  output urbuf_pkg::cmd_t                cmd,
  input  wire logic                      cmd_take
);
  import urbuf_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  op_t        op_dec;

  // Classify the mode into an operation.
  always_comb begin
    unique case (in_mode)
      MODE_RX_BYTE: op_dec = OP_RX_PUT;
      MODE_PEEK:    op_dec = OP_PEEK;
      MODE_READ:    op_dec = OP_READ;
      MODE_WRITE:   op_dec = OP_TX_PUT;
      MODE_TX_DONE: op_dec = OP_TX_DONE;
      default:      op_dec = OP_NONE;
    endcase
  end

  // Two-entry command queue between the front and the back.
  assign in_stall  = count_r[1];
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != 2'd0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op_dec, data: in_byte_in};
    end
  end

  // The queue never holds more than two commands.
  assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("command queue count out of range");

  // A pushed command leaves the queue non-empty on the next edge.
  assert property (@(posedge clk) disable iff (!rst_n) push |=> cmd_valid)
    else $error("pushed command lost");

  // The queue count grows by one on a push without a pop.
  assert property (@(posedge clk) disable iff (!rst_n)
      (push && !pop) |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count did not grow on push");

endmodule

`default_nettype wire

// File: rtl/core/urbuf_back.sv
// Back end: ring memories, pointers and the result register.
`default_nettype none

module urbuf_back (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_valid,
  input  wire urbuf_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          out_valid,
  input  wire logic     out_stall,
  output urbuf_pkg::res_t out_res
);
  import urbuf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r;
  logic [BYTE_W-1:0]   rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0]   tx_mem [TX_DEPTH];
  logic [BYTE_W-1:0]   rx_rd_r;
  logic [BYTE_W-1:0]   tx_rd_r;
  logic [RX_PTR_W-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [TX_PTR_W-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic                busy_r, busy_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                res_r, res_nxt;
  logic                fire;
  logic                rx_we, tx_we;
  logic                rx_empty, rx_full, tx_empty, tx_full;
  logic [RX_PTR_W-1:0] rx_head_adv;
  logic [TX_PTR_W-1:0] tx_head_adv;

  // Sequencer: take a command and read both tails, then execute.
  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd_take) state_nxt = S_EXEC;
      S_EXEC: if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Ring status from the current pointers.
  always_comb begin
    rx_head_adv = rx_adv(rx_head_r);
    tx_head_adv = tx_adv(tx_head_r);
    rx_empty    = (rx_head_r == rx_tail_r);
    tx_empty    = (tx_head_r == tx_tail_r);
    rx_full     = (rx_head_adv == rx_tail_r);
    tx_full     = (tx_head_adv == tx_tail_r);
  end

  // Execute the held command and form the result beat.
  always_comb begin
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    busy_nxt    = busy_r;
    rx_we       = 1'b0;
    tx_we       = 1'b0;
    res_nxt     = '0;
    case (cmd_r.op) inside
      OP_RX_PUT: begin
        if (rx_full) begin
          res_nxt.rx_dropped = 1'b1;
        end else begin
          rx_we       = 1'b1;
          rx_head_nxt = rx_head_adv;
        end
      end
      OP_PEEK, OP_READ: begin
        if (!rx_empty) begin
          res_nxt.data_out   = rx_rd_r;
          res_nxt.data_valid = 1'b1;
          if (cmd_r.op == OP_READ) begin
            rx_tail_nxt = rx_adv(rx_tail_r);
          end
        end
      end
      OP_TX_PUT: begin
        if (tx_full) begin
          res_nxt.write_rejected = 1'b1;
        end else begin
          tx_we       = 1'b1;
          tx_head_nxt = tx_head_adv;
          // An idle transmitter takes the oldest byte at once; on an empty
          // ring that is the byte being written.
          if (!busy_r) begin
            res_nxt.send_valid = 1'b1;
            res_nxt.send_byte  = tx_empty ? cmd_r.data : tx_rd_r;
            tx_tail_nxt        = tx_adv(tx_tail_r);
            busy_nxt           = 1'b1;
          end
        end
      end
      OP_TX_DONE: begin
        busy_nxt = 1'b0;
        if (!tx_empty) begin
          res_nxt.send_valid = 1'b1;
          res_nxt.send_byte  = tx_rd_r;
          tx_tail_nxt        = tx_adv(tx_tail_r);
          busy_nxt           = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_nxt.rx_count = CNT_W'(rx_fill(rx_head_nxt, rx_tail_nxt));
    res_nxt.tx_count = CNT_W'(tx_fill(tx_head_nxt, tx_tail_nxt));
  end

  // Result register valid.
  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        rx_head_r <= rx_head_nxt;
        rx_tail_r <= rx_tail_nxt;
        tx_head_r <= tx_head_nxt;
        tx_tail_r <= tx_tail_nxt;
        busy_r    <= busy_nxt;
      end
    end
  end

  // Held command and result payload.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_r <= cmd;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  // Receive ring memory with registered read at the tail.
  always_ff @(posedge clk) begin
    if (fire && rx_we) begin
      rx_mem[rx_head_r] <= cmd_r.data;
    end
    if (cmd_take) begin
      rx_rd_r <= rx_mem[rx_tail_r];
    end
  end

  // Transmit ring memory with registered read at the tail.
  always_ff @(posedge clk) begin
    if (fire && tx_we) begin
      tx_mem[tx_head_r] <= cmd_r.data;
    end
    if (cmd_take) begin
      tx_rd_r <= tx_mem[tx_tail_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // A taken command is executed in the following cycle or later.
  assert property (@(posedge clk) disable iff (!rst_n) cmd_take |=> state_r == S_EXEC)
    else $error("taken command not held for execution");

  // A dropped byte means the receive ring was full and stays full.
  assert property (@(posedge clk) disable iff (!rst_n)
      (fire && res_nxt.rx_dropped) |-> res_nxt.rx_count == CNT_W'(RX_DEPTH - 1))
    else $error("byte dropped from a ring that was not full");

  // Peek or read data only comes from a peek or read command.
  assert property (@(posedge clk) disable iff (!rst_n)
      (fire && res_nxt.data_valid) |-> (cmd_r.op == OP_PEEK || cmd_r.op == OP_READ))
    else $error("data beat from a command that does not read");

  // Handing a byte to the transmitter leaves it busy.
  assert property (@(posedge clk) disable iff (!rst_n)
      (fire && res_nxt.send_valid) |=> busy_r)
    else $error("transmitter idle after a send");

endmodule

`default_nettype wire

// File: rtl/core/uart_rx_tx_ring_buffers_core.sv
// Top level of the serial receive and transmit ring buffer pair.
// An accepted item beat passes through the command queue, the held command register
// and the result register. The back end reads both ring tails as it takes a command
// and takes no new one until that command has executed, which a stalled result delays.
// A two-entry command queue lets the input side keep accepting while a result waits.
// Reset clears the pointers, the transmitter state, the queue and the result valid;
// the ring memories are not cleared and need no clearing pass.
`default_nettype none

module uart_rx_tx_ring_buffers_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_mode,
  input  wire logic [7:0] in_byte_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_data_out,
  output logic            out_data_valid,
  output logic            out_rx_dropped,
  output logic            out_write_rejected,
  output logic            out_send_valid,
  output logic [7:0]      out_send_byte,
  output logic [5:0]      out_rx_count,
  output logic [5:0]      out_tx_count
);
  import urbuf_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  res_t res;

  // Front end: accept and classify.
  urbuf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_byte_in (in_byte_in),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  // Back end: rings and result register.
  urbuf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  // Result fields onto their ports.
  assign out_data_out       = res.data_out;
  assign out_data_valid     = res.data_valid;
  assign out_rx_dropped     = res.rx_dropped;
  assign out_write_rejected = res.write_rejected;
  assign out_send_valid     = res.send_valid;
  assign out_send_byte      = res.send_byte;
  assign out_rx_count       = res.rx_count;
  assign out_tx_count       = res.tx_count;

endmodule

`default_nettype wire
